// File: hw/rtl/hps_pkg.sv
// Shared types and constants for the halfcomplex power spectrum block.
// Used by hps_front, hps_back and halfcomplex_power_spectrum; no dependencies.
`timescale 1ns / 1ps

package hps_pkg;

    // Fixed field widths
    localparam int COEF_W = 16;   // signed coefficient
    localparam int POS_W  = 11;   // frame size / position in frame
    localparam int BIN_W  = 10;   // bin index on the result side
    localparam int POW_W  = 32;   // exact power

    localparam int MAX_FRAME_DEF = 1024;
    localparam logic [POS_W-1:0] FRAME_SIZE_RST = 11'd1024;

    localparam int OP_Q_DEPTH  = 4;
    localparam int RES_Q_DEPTH = 4;

    // What the back end does with one queued beat
    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,  // keep the real part in the half-frame store
        OP_SINGLE = 2'd1,  // power is coefficient squared
        OP_PAIR   = 2'd2   // power is stored real squared plus coefficient squared
    } t_op_kind;

    typedef struct packed {
        t_op_kind                 kind;
        logic [POS_W-1:0]         idx;   // store address or bin
        logic signed [COEF_W-1:0] coef;
        logic                     last;
    } t_op;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [POW_W-1:0] power;
        logic             last;
    } t_result;

endpackage

// File: hw/rtl/hps_queue.sv
// Small first-in first-out queue of packed beats held in flip-flops.
// Generic, no package dependency; used for the op and result queues.
`timescale 1ns / 1ps

module hps_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic [CNT_W-1:0]  o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_full |=> r_count == $past(r_count) || $past(i_pop))
        else $error("queue pushed while full");

endmodule

// File: hw/rtl/hps_front.sv
// Front end: frame size register, position in frame, classification of each beat.
// Depends on hps_pkg; feeds the op queue ahead of hps_back.
`timescale 1ns / 1ps

module hps_front #(
    parameter int MAX_FRAME = hps_pkg::MAX_FRAME_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hps_pkg::POS_W-1:0]        i_cfg_wdata,
    input  logic                             i_push,
    input  logic signed [hps_pkg::COEF_W-1:0] i_coefficient,
    input  logic                             i_q_full,
    output logic                             o_full,
    output logic                             o_op_push,
    output hps_pkg::t_op                     o_op
);
    import hps_pkg::*;

    localparam int STORE_DEPTH = MAX_FRAME / 2;

    logic [POS_W-1:0] r_frame_size;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] n_eff;
    logic [POS_W:0]   half_up;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] k;
    logic             is_last;
    logic             accept;
    logic             p_in_store, k_in_store;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // Effective frame size: zero reads as one, saturated at the maximum
    always_comb begin
        if (r_frame_size == '0) begin
            n_eff = POS_W'(1);
        end else if (32'(r_frame_size) > 32'(MAX_FRAME)) begin
            n_eff = POS_W'(MAX_FRAME);
        end else begin
            n_eff = r_frame_size;
        end
    end

    assign half_up    = ({1'b0, n_eff} + 1'b1) >> 1;
    assign p          = (r_pos >= n_eff) ? '0 : r_pos;
    assign k          = n_eff - p;
    assign is_last    = ({1'b0, p} + 1'b1) == {1'b0, n_eff};
    assign n_pos      = is_last ? '0 : p + 1'b1;
    assign p_in_store = 32'(p) < 32'(STORE_DEPTH);
    assign k_in_store = 32'(k) < 32'(STORE_DEPTH);

    // Classify the beat by its position in the frame
    always_comb begin
        o_op_push = 1'b0;
        o_op.kind = OP_SINGLE;
        o_op.idx  = p;
        o_op.coef = i_coefficient;
        o_op.last = is_last;
        priority if (p == '0) begin
            o_op_push = accept;
        end else if ({1'b0, p} < half_up) begin
            o_op.kind = OP_STORE;
            o_op_push = accept && p_in_store;
        end else if (!n_eff[0] && p == (n_eff >> 1)) begin
            o_op_push = accept;
        end else begin
            o_op.idx  = k;
            o_op.kind = k_in_store ? OP_PAIR : OP_SINGLE;
            o_op_push = accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= FRAME_SIZE_RST;
            r_pos        <= '0;
        end else if (i_cfg_we) begin
            r_frame_size <= i_cfg_wdata;
            r_pos        <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < n_eff)
        else $error("frame position outside frame");

endmodule

// File: hw/rtl/hps_back.sv
// Back end: half-frame real-part store, squaring pipeline and result queue.
// Depends on hps_pkg and hps_queue; drains the op queue filled by hps_front.
`timescale 1ns / 1ps

module hps_back #(
    parameter int MAX_FRAME = hps_pkg::MAX_FRAME_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_op_empty,
    input  hps_pkg::t_op    i_op,
    output logic            o_op_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output hps_pkg::t_result o_result
);
    import hps_pkg::*;

    localparam int STORE_DEPTH = (MAX_FRAME / 2 > 0) ? MAX_FRAME / 2 : 1;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int RES_W       = $bits(t_result);
    localparam int CNT_W       = $clog2(RES_Q_DEPTH + 1);

    logic signed [COEF_W-1:0] r_store [STORE_DEPTH];

    logic [31:0]       idx_ext;
    logic [ADDR_W-1:0] addr;
    logic              credit_ok;
    logic              issue;
    logic [CNT_W-1:0]  res_count;
    logic              res_full;

    // Stage 1: op taken, store read
    logic                     r_v1;
    logic                     r_pair1;
    logic signed [COEF_W-1:0] r_coef1;
    logic signed [COEF_W-1:0] r_rd1;
    logic [BIN_W-1:0]         r_bin1;
    logic                     r_last1;

    // Stage 2: squares
    logic                     r_v2;
    logic [POW_W-1:0]         r_sqx2;
    logic [POW_W-1:0]         r_sqr2;
    logic [BIN_W-1:0]         r_bin2;
    logic                     r_last2;

    logic signed [2*COEF_W-1:0] prod_x, prod_r;
    t_result                    res_in;

    assign idx_ext = 32'(i_op.idx);
    assign addr    = idx_ext[ADDR_W-1:0];

    // Only start a result when the result queue has a slot for it
    assign credit_ok = (32'(res_count) + 32'(r_v1) + 32'(r_v2)) < 32'(RES_Q_DEPTH);
    assign issue     = !i_op_empty && (i_op.kind == OP_STORE || credit_ok);
    assign o_op_pop  = issue;

    // Half-frame store: write on store beats, registered read on pair beats
    always_ff @(posedge i_clk) begin
        if (issue && i_op.kind == OP_STORE) begin
            r_store[addr] <= i_op.coef;
        end
        if (issue && i_op.kind == OP_PAIR) begin
            r_rd1 <= r_store[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pair1 <= (i_op.kind == OP_PAIR);
            r_coef1 <= i_op.coef;
            r_bin1  <= i_op.idx[BIN_W-1:0];
            r_last1 <= i_op.last;
        end
    end

    // Squaring
    assign prod_x = r_coef1 * r_coef1;
    assign prod_r = r_rd1 * r_rd1;

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_sqx2  <= $unsigned(prod_x);
            r_sqr2  <= r_pair1 ? $unsigned(prod_r) : '0;
            r_bin2  <= r_bin1;
            r_last2 <= r_last1;
        end
    end

    // Valid flags of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue && (i_op.kind != OP_STORE);
            r_v2 <= r_v1;
        end
    end

    // Final add into the result queue
    always_comb begin
        res_in.bin   = r_bin2;
        res_in.power = r_sqx2 + r_sqr2;
        res_in.last  = r_last2;
    end

    hps_queue #(
        .DATA_W (RES_W),
        .DEPTH  (RES_Q_DEPTH),
        .CNT_W  (CNT_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v2),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty),
        .o_count (res_count)
    );

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> !res_full)
        else $error("result beat arrives at a full result queue");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(res_count) + 32'(r_v1) + 32'(r_v2)) <= 32'(RES_Q_DEPTH))
        else $error("results in flight exceed result queue room");

endmodule

// File: hw/rtl/halfcomplex_power_spectrum.sv
// Top level of the halfcomplex power spectrum block.
// Depends on hps_pkg, hps_queue, hps_front and hps_back.
`timescale 1ns / 1ps
//
// Usage:
//   Input side is a queue: drive i_coefficient and raise i_push; a beat is taken
//   at a clock edge with i_push high and o_full low. One halfcomplex FFT
//   coefficient per beat: r0, r1 .. r(N/2), then i((N+1)/2-1) down to i1.
//   Result side is a queue: while o_empty is low the oldest result sits on
//   o_bin_index / o_power / o_last; it is taken on an edge with i_pop high.
//   o_last marks the final bin of each frame.
//   Config: i_cfg_we with i_cfg_wdata writes the frame size N (0 reads as 1,
//   above MAX_FRAME saturates) and restarts the frame. Write only while idle.
// Timing:
//   One coefficient per cycle sustained while o_full is low; the single-ported
//   store access and two 16x16 squarers are each used once per beat. A result
//   passes the op queue, the store read stage and the squaring stage in order.
//   Coefficients for bins 1..(N+1)/2-1 only fill the store and make no result.
//   If pop is held low the four-entry result queue fills, the back end stops
//   and the four-entry op queue behind it fills, then o_full rises.
// Reset: synchronous, active low; frame size returns to 1024, both queues empty.
//
module halfcomplex_power_spectrum #(
    parameter int MAX_FRAME = hps_pkg::MAX_FRAME_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hps_pkg::POS_W-1:0]          i_cfg_wdata,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic signed [hps_pkg::COEF_W-1:0]  i_coefficient,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [hps_pkg::BIN_W-1:0]          o_bin_index,
    output logic [hps_pkg::POW_W-1:0]          o_power,
    output logic                               o_last
);
    import hps_pkg::*;

    localparam int OP_W     = $bits(t_op);
    localparam int OP_CNT_W = $clog2(OP_Q_DEPTH + 1);

    logic                op_push, op_pop, op_full, op_empty;
    logic [OP_CNT_W-1:0] op_count;
    t_op                 op_in, op_out;
    t_result             result;

    hps_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (i_push),
        .i_coefficient (i_coefficient),
        .i_q_full      (op_full),
        .o_full        (o_full),
        .o_op_push     (op_push),
        .o_op          (op_in)
    );

    // Decoupling queue between front and back
    hps_queue #(
        .DATA_W (OP_W),
        .DEPTH  (OP_Q_DEPTH),
        .CNT_W  (OP_CNT_W)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (op_out),
        .o_empty (op_empty),
        .o_count (op_count)
    );

    hps_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (op_empty),
        .i_op       (op_out),
        .o_op_pop   (op_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_result   (result)
    );

    assign o_bin_index = result.bin;
    assign o_power     = result.power;
    assign o_last      = result.last;

    a_full_at_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full == (op_count == OP_CNT_W'(OP_Q_DEPTH)))
        else $error("input full flag disagrees with op queue fill");

endmodule
